// ===== hdl/psc_pkg.sv =====
// Package for the pixel mask sprite collision block.
// Holds field widths, register indexes, mode codes, reset values and the state type.
// No dependencies.
package psc_pkg;

    localparam int MAX_SPRITE_W = 64;
    localparam int MAX_SPRITE_H = 64;
    localparam int COLOR_BITS   = 16;
    localparam int COORD_BITS   = 12;

    localparam int MODE_W   = 2;
    localparam int PIX_W    = 6;
    localparam int PCOLOR_W = 16;
    localparam int POS_W    = 12;
    localparam int MASK_W   = 16;
    localparam int SIZE_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MASK_W-1:0] MASK_RESET = 16'd63519;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_TEST   = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_A   = 3'd0,
        CFG_MASK_B   = 3'd1,
        CFG_WIDTH_A  = 3'd2,
        CFG_HEIGHT_A = 3'd3,
        CFG_WIDTH_B  = 3'd4,
        CFG_HEIGHT_B = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_SPAN,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/psc_if.sv =====
// Channel interfaces of the sprite collision block: request, result and register write.
// Depends on psc_pkg for field widths.
interface psc_req_if;
    logic                                valid;
    logic                                ready;
    logic [psc_pkg::MODE_W-1:0]          mode;
    logic [psc_pkg::PIX_W-1:0]           pixel_col;
    logic [psc_pkg::PIX_W-1:0]           pixel_row;
    logic [psc_pkg::PCOLOR_W-1:0]        pixel_color;
    logic signed [psc_pkg::POS_W-1:0]    pos_a_x;
    logic signed [psc_pkg::POS_W-1:0]    pos_a_y;
    logic signed [psc_pkg::POS_W-1:0]    pos_b_x;
    logic signed [psc_pkg::POS_W-1:0]    pos_b_y;

    modport source (output valid, mode, pixel_col, pixel_row, pixel_color,
                    pos_a_x, pos_a_y, pos_b_x, pos_b_y, input ready);
    modport sink   (input valid, mode, pixel_col, pixel_row, pixel_color,
                    pos_a_x, pos_a_y, pos_b_x, pos_b_y, output ready);
endinterface

interface psc_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

interface psc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [psc_pkg::CFG_IDX_W-1:0]     index;
    logic [psc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pixel_mask_sprite_collision_top.sv =====
// Top level of the pixel mask sprite collision block: pixel stores, scan sequencer, registers.
// Depends on psc_pkg and the channel interfaces in psc_if.sv.
//
//  channel | dir | payload                                         | request accepted
//  req     | in  | mode, pixel_col/row/color, pos_a/b_x/y          | req.valid & req.ready
//  rsp     | out | hit (one per collision test)                    | rsp.valid & rsp.ready
//  cfg     | in  | index, data                                     | cfg.valid & cfg.ready
//
// Pixel loads and unused modes complete on acceptance. A test runs bound setup and ends there when the
// boxes miss, else scans the overlap at one pixel pair per cycle, read from both stores at once and
// checked by one comparator, stopping at the first opaque pair.
// req.ready is low while a test runs; a finished test holds in its last cycle for as long as
// the previous result still waits unaccepted in the output register.
// Reset clears control and sets the config registers to their reset values; the pixel stores hold garbage until loaded.
module pixel_mask_sprite_collision_top #(
    parameter int MAX_SPRITE_W = psc_pkg::MAX_SPRITE_W,
    parameter int MAX_SPRITE_H = psc_pkg::MAX_SPRITE_H,
    parameter int COLOR_BITS   = psc_pkg::COLOR_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    psc_req_if.sink      req,
    psc_rsp_if.source    rsp,
    psc_cfg_if.sink      cfg
);

    localparam int DEPTH    = MAX_SPRITE_W * MAX_SPRITE_H;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW       = (MAX_SPRITE_W > 1) ? $clog2(MAX_SPRITE_W) : 1;
    localparam int RW       = (MAX_SPRITE_H > 1) ? $clog2(MAX_SPRITE_H) : 1;
    localparam int MAX_SIDE = (MAX_SPRITE_W > MAX_SPRITE_H) ? MAX_SPRITE_W : MAX_SPRITE_H;
    localparam int SW       = $clog2(MAX_SIDE + 1);
    localparam int CI       = psc_pkg::COORD_BITS + SW + 1;

    logic [COLOR_BITS-1:0] mem_a [DEPTH];
    logic [COLOR_BITS-1:0] mem_b [DEPTH];

    psc_pkg::state_t state_reg, state_next;

    logic [psc_pkg::MASK_W-1:0] mask_a_reg, mask_b_reg;
    logic [psc_pkg::SIZE_W-1:0] width_a_reg, height_a_reg, width_b_reg, height_b_reg;

    logic signed [CI-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [CI-1:0] ax_next, ay_next, bx_next, by_next;
    logic signed [CI-1:0] eax_reg, eay_reg, ebx_reg, eby_reg;
    logic signed [CI-1:0] eax_next, eay_next, ebx_next, eby_next;
    logic signed [CI-1:0] x0_reg, y0_reg, x0_next, y0_next;

    logic [XW-1:0] xa_reg, xb_reg, ca0_reg, cb0_reg;
    logic [XW-1:0] xa_next, xb_next, ca0_next, cb0_next;
    logic [RW-1:0] ya_reg, yb_reg, ya_next, yb_next;
    logic [SW-1:0] col_reg, row_reg, ow_reg, oh_reg;
    logic [SW-1:0] col_next, row_next, ow_next, oh_next;

    logic rd_vld_reg, rd_vld_next;
    logic res_hit_reg, res_hit_next;
    logic out_valid_reg, out_valid_next;
    logic hit_reg, hit_next;

    logic [COLOR_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0]         rd_addr_a, rd_addr_b, wr_addr;
    logic [COLOR_BITS-1:0] wr_color;
    logic                  we_a, we_b;

    logic [SW-1:0]         wa, ha, wb, hb;
    logic signed [CI-1:0]  owa, owb, oha, ohb, ow_s, oh_s;
    logic                  pix_hit, col_end, last_pix, load_ok, req_fire;

    // Sizes saturate at the store dimensions
    assign wa = (int'(width_a_reg)  > MAX_SPRITE_W) ? SW'(MAX_SPRITE_W) : SW'(width_a_reg);
    assign ha = (int'(height_a_reg) > MAX_SPRITE_H) ? SW'(MAX_SPRITE_H) : SW'(height_a_reg);
    assign wb = (int'(width_b_reg)  > MAX_SPRITE_W) ? SW'(MAX_SPRITE_W) : SW'(width_b_reg);
    assign hb = (int'(height_b_reg) > MAX_SPRITE_H) ? SW'(MAX_SPRITE_H) : SW'(height_b_reg);

    assign owa  = eax_reg - x0_reg;
    assign owb  = ebx_reg - x0_reg;
    assign oha  = eay_reg - y0_reg;
    assign ohb  = eby_reg - y0_reg;
    assign ow_s = (owa < owb) ? owa : owb;
    assign oh_s = (oha < ohb) ? oha : ohb;

    assign pix_hit  = (rd_a_reg != COLOR_BITS'(mask_a_reg))
                   && (rd_b_reg != COLOR_BITS'(mask_b_reg));
    assign col_end  = ((col_reg + SW'(1)) == ow_reg);
    assign last_pix = col_end && ((row_reg + SW'(1)) == oh_reg);

    assign rd_addr_a = AW'(ya_reg) * AW'(MAX_SPRITE_W) + AW'(xa_reg);
    assign rd_addr_b = AW'(yb_reg) * AW'(MAX_SPRITE_W) + AW'(xb_reg);
    assign wr_addr   = AW'(RW'(req.pixel_row)) * AW'(MAX_SPRITE_W) + AW'(XW'(req.pixel_col));
    assign wr_color  = COLOR_BITS'(req.pixel_color);

    assign req.ready = (state_reg == psc_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign load_ok   = (int'(req.pixel_col) < MAX_SPRITE_W)
                    && (int'(req.pixel_row) < MAX_SPRITE_H);
    assign we_a = req_fire && load_ok && (req.mode == psc_pkg::MODE_LOAD_A);
    assign we_b = req_fire && load_ok && (req.mode == psc_pkg::MODE_LOAD_B);

    assign rsp.valid = out_valid_reg;
    assign rsp.hit   = hit_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= wr_color;
        end
        if (we_b)
        begin
            mem_b[wr_addr] <= wr_color;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_a_reg   <= psc_pkg::MASK_RESET;
            mask_b_reg   <= psc_pkg::MASK_RESET;
            width_a_reg  <= psc_pkg::SIZE_RESET;
            height_a_reg <= psc_pkg::SIZE_RESET;
            width_b_reg  <= psc_pkg::SIZE_RESET;
            height_b_reg <= psc_pkg::SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                psc_pkg::CFG_MASK_A:   mask_a_reg   <= cfg.data;
                psc_pkg::CFG_MASK_B:   mask_b_reg   <= cfg.data;
                psc_pkg::CFG_WIDTH_A:  width_a_reg  <= cfg.data[psc_pkg::SIZE_W-1:0];
                psc_pkg::CFG_HEIGHT_A: height_a_reg <= cfg.data[psc_pkg::SIZE_W-1:0];
                psc_pkg::CFG_WIDTH_B:  width_b_reg  <= cfg.data[psc_pkg::SIZE_W-1:0];
                psc_pkg::CFG_HEIGHT_B: height_b_reg <= cfg.data[psc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psc_pkg::ST_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            res_hit_reg   <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            res_hit_reg   <= res_hit_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        bx_reg  <= bx_next;
        by_reg  <= by_next;
        eax_reg <= eax_next;
        eay_reg <= eay_next;
        ebx_reg <= ebx_next;
        eby_reg <= eby_next;
        x0_reg  <= x0_next;
        y0_reg  <= y0_next;
        xa_reg  <= xa_next;
        xb_reg  <= xb_next;
        ya_reg  <= ya_next;
        yb_reg  <= yb_next;
        ca0_reg <= ca0_next;
        cb0_reg <= cb0_next;
        col_reg <= col_next;
        row_reg <= row_next;
        ow_reg  <= ow_next;
        oh_reg  <= oh_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        eax_next       = eax_reg;
        eay_next       = eay_reg;
        ebx_next       = ebx_reg;
        eby_next       = eby_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        xa_next        = xa_reg;
        xb_next        = xb_reg;
        ya_next        = ya_reg;
        yb_next        = yb_reg;
        ca0_next       = ca0_reg;
        cb0_next       = cb0_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ow_next        = ow_reg;
        oh_next        = oh_reg;
        res_hit_next   = res_hit_reg;
        hit_next       = hit_reg;
        rd_vld_next    = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (req_fire && (req.mode == psc_pkg::MODE_TEST))
                begin
                    ax_next    = CI'(req.pos_a_x);
                    ay_next    = CI'(req.pos_a_y);
                    bx_next    = CI'(req.pos_b_x);
                    by_next    = CI'(req.pos_b_y);
                    state_next = psc_pkg::ST_BOUND;
                end
            end
            psc_pkg::ST_BOUND:
            begin
                eax_next   = ax_reg + $signed(CI'(wa));
                eay_next   = ay_reg + $signed(CI'(ha));
                ebx_next   = bx_reg + $signed(CI'(wb));
                eby_next   = by_reg + $signed(CI'(hb));
                x0_next    = (ax_reg > bx_reg) ? ax_reg : bx_reg;
                y0_next    = (ay_reg > by_reg) ? ay_reg : by_reg;
                state_next = psc_pkg::ST_SPAN;
            end
            psc_pkg::ST_SPAN:
            begin
                ca0_next = XW'(x0_reg - ax_reg);
                cb0_next = XW'(x0_reg - bx_reg);
                xa_next  = XW'(x0_reg - ax_reg);
                xb_next  = XW'(x0_reg - bx_reg);
                ya_next  = RW'(y0_reg - ay_reg);
                yb_next  = RW'(y0_reg - by_reg);
                ow_next  = SW'(ow_s);
                oh_next  = SW'(oh_s);
                col_next = '0;
                row_next = '0;
                if ((ow_s <= 0) || (oh_s <= 0))
                begin
                    res_hit_next = 1'b0;
                    state_next   = psc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = psc_pkg::ST_SCAN;
                end
            end
            psc_pkg::ST_SCAN:
            begin
                if (rd_vld_reg && pix_hit)
                begin
                    res_hit_next = 1'b1;
                    state_next   = psc_pkg::ST_DONE;
                end
                else
                begin
                    rd_vld_next = 1'b1;
                    if (col_end)
                    begin
                        col_next = '0;
                        xa_next  = ca0_reg;
                        xb_next  = cb0_reg;
                        ya_next  = ya_reg + RW'(1);
                        yb_next  = yb_reg + RW'(1);
                        row_next = row_reg + SW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + SW'(1);
                        xa_next  = xa_reg + XW'(1);
                        xb_next  = xb_reg + XW'(1);
                    end
                    if (last_pix)
                    begin
                        state_next = psc_pkg::ST_LAST;
                    end
                end
            end
            psc_pkg::ST_LAST:
            begin
                res_hit_next = pix_hit;
                state_next   = psc_pkg::ST_DONE;
            end
            psc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    state_next     = psc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
